### sv/saq_pkg.sv
`default_nettype none
package saq_pkg;

   // table geometry
   localparam int NUM_ALARMS = 16;
   localparam int ID_W       = $clog2(NUM_ALARMS);
   localparam int LINK_W     = $clog2(NUM_ALARMS + 1);

   // fixed field widths
   localparam int IN_ID_W = 4;
   localparam int TIME_W  = 32;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 5;

   // end-of-list / empty marker
   localparam logic [LINK_W-1:0] NOT_PLACED = LINK_W'(NUM_ALARMS);

   // status codes
   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_QUEUED   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_NOW  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_REL  = 2'd3;

   // classified request passed from front to back
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] rel;
      logic [TIME_W-1:0] now;
      logic [STAT_W-1:0] err;
   } cmd_type;

endpackage
`default_nettype wire

### sv/saq_req_if.sv
`default_nettype none
interface saq_req_if;
   logic                        valid;
   logic                        ready;
   logic [saq_pkg::IN_ID_W-1:0] alarm_id;
   logic [saq_pkg::TIME_W-1:0]  rel_ticks;
   logic [saq_pkg::TIME_W-1:0]  counter_now;

   modport source (output valid, alarm_id, rel_ticks, counter_now, input ready);
   modport sink   (input valid, alarm_id, rel_ticks, counter_now, output ready);
endinterface
`default_nettype wire

### sv/saq_rsp_if.sv
`default_nettype none
interface saq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [saq_pkg::STAT_W-1:0] status;
   logic [saq_pkg::TIME_W-1:0] extended_now;
   logic [saq_pkg::TIME_W-1:0] due_time;
   logic [saq_pkg::POS_W-1:0]  queue_position;
   logic [saq_pkg::POS_W-1:0]  head_id;

   modport source (output valid, status, extended_now, due_time, queue_position, head_id,
                   input ready);
   modport sink   (input valid, status, extended_now, due_time, queue_position, head_id,
                   output ready);
endinterface
`default_nettype wire

### sv/sorted_alarm_queue_insert_core.sv
// Sorted alarm queue insert.
// req_ch carries one insert request (alarm_id, rel_ticks, counter_now) per
// valid/ready handshake; rsp_ch returns one result per request, in order.
// csr_we/csr_wdata write max_count (reset 65535); write it only when idle.
// The front takes a request, range-checks it against max_count and queues
// it in a two-entry queue; ready is high while that queue has room.
// The back extends the running time, writes the due time and walks the
// linked queue one entry per cycle through the registered table read port.
// A rejected request is answered from the idle state; an accepted one
// passes the delta, extend and due states, answered there if the queue
// was empty, else from the head state as new head, else from the link
// state after walking to position p (1 to NUM_ALARMS - 1). One request at
// a time; the back takes the next in the cycle its result leaves.
// A stalled rsp_ch holds its result; the back waits and the front keeps
// taking requests until its queue is full.
// Synchronous reset empties the alarm queue, zeroes the running time and
// restores max_count; no clearing pass is needed.
`default_nettype none
module sorted_alarm_queue_insert_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   saq_req_if.sink                         req_ch,
   saq_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_we,
   input  wire logic [saq_pkg::TIME_W-1:0] csr_wdata
);

   logic [saq_pkg::TIME_W-1:0] max_count_ff, max_count_in;
   saq_pkg::cmd_type           cmd;
   logic                       cmd_valid;
   logic                       cmd_pop;

   // configuration register
   assign max_count_in = csr_we ? csr_wdata : max_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= saq_pkg::TIME_W'(65535);
      end else begin
         max_count_ff <= max_count_in;
      end
   end

   saq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .max_count (max_count_ff),
      .req       (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   saq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .max_count (max_count_ff),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_ch)
   );

endmodule
`default_nettype wire

### sv/saq_front.sv
`default_nettype none
module saq_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [saq_pkg::TIME_W-1:0] max_count,
   saq_req_if.sink                         req,
   output saq_pkg::cmd_type                cmd,
   output logic                            cmd_valid,
   input  wire logic                       cmd_pop
);

   localparam int DEPTH = 2;

   saq_pkg::cmd_type       entry_in;
   saq_pkg::cmd_type       slot_ff [DEPTH];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push;

   assign req.ready = (count_ff < 2'(DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // range checks; the reading is checked first
   always_comb begin
      entry_in.id  = saq_pkg::ID_W'(req.alarm_id % saq_pkg::NUM_ALARMS);
      entry_in.rel = req.rel_ticks;
      entry_in.now = req.counter_now;
      if (req.counter_now > max_count) begin
         entry_in.err = saq_pkg::ST_BAD_NOW;
      end else if (req.rel_ticks > max_count) begin
         entry_in.err = saq_pkg::ST_BAD_REL;
      end else begin
         entry_in.err = saq_pkg::ST_INSERTED;
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

### sv/saq_back.sv
`default_nettype none
module saq_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [saq_pkg::TIME_W-1:0] max_count,
   input  wire saq_pkg::cmd_type           cmd,
   input  wire logic                       cmd_valid,
   output logic                            cmd_pop,
   saq_rsp_if.source                       rsp
);

   localparam int ID_W   = saq_pkg::ID_W;
   localparam int LINK_W = saq_pkg::LINK_W;
   localparam int TW     = saq_pkg::TIME_W;
   localparam int NA     = saq_pkg::NUM_ALARMS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DELTA = 3'd1;
   localparam logic [2:0] S_EXT   = 3'd2;
   localparam logic [2:0] S_DUE   = 3'd3;
   localparam logic [2:0] S_HEAD  = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;

   // wrap-aware: a strictly before b
   function automatic logic is_before(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [TW-1:0] d;
      d = a - b;
      return d[TW-1];
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TW-1:0]     rel_ff, rel_in;
   logic [TW-1:0]     now_ff, now_in;
   logic [TW-1:0]     delta_ff, delta_in;
   logic [TW-1:0]     due_ff, due_in;
   logic [TW-1:0]     ext_ff, ext_in;
   logic [TW-1:0]     last_ff, last_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [NA-1:0]     in_queue_ff, in_queue_in;
   logic [ID_W-1:0]   prior_ff, prior_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] pos_ff, pos_in;
   logic [LINK_W-1:0] guard_ff, guard_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [saq_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TW-1:0]              rsp_ext_ff, rsp_ext_in;
   logic [TW-1:0]              rsp_due_ff, rsp_due_in;
   logic [saq_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [saq_pkg::POS_W-1:0]  rsp_head_ff, rsp_head_in;

   // link and due tables
   logic [TW-1:0]     due_mem  [NA];
   logic [LINK_W-1:0] next_mem [NA];
   logic [TW-1:0]     rd_due_ff;
   logic [LINK_W-1:0] rd_next_ff;
   logic [ID_W-1:0]   rd_addr;
   logic              due_we;
   logic              next_we;
   logic [ID_W-1:0]   next_wa;
   logic [LINK_W-1:0] next_wd;

   logic              out_free;
   logic [TW-1:0]     due_sum;
   logic              walk_end;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign due_sum   = ext_ff + rel_ff;
   assign walk_end  = (cur_ff >= LINK_W'(NA)) || (guard_ff >= LINK_W'(NA)) ||
                      is_before(due_ff, rd_due_ff);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.extended_now   = rsp_ext_ff;
   assign rsp.due_time       = rsp_due_ff;
   assign rsp.queue_position = rsp_pos_ff;
   assign rsp.head_id        = rsp_head_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      rel_in       = rel_ff;
      now_in       = now_ff;
      delta_in     = delta_ff;
      due_in       = due_ff;
      ext_in       = ext_ff;
      last_in      = last_ff;
      head_in      = head_ff;
      in_queue_in  = in_queue_ff;
      prior_in     = prior_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      guard_in     = guard_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_ext_in   = rsp_ext_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_head_in  = rsp_head_ff;
      cmd_pop      = 1'b0;
      rd_addr      = '0;
      due_we       = 1'b0;
      next_we      = 1'b0;
      next_wa      = id_ff;
      next_wd      = saq_pkg::NOT_PLACED;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               id_in   = cmd.id;
               rel_in  = cmd.rel;
               now_in  = cmd.now;
               if (cmd.err != saq_pkg::ST_INSERTED || in_queue_ff[cmd.id]) begin
                  // rejected request: nothing changes
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (cmd.err != saq_pkg::ST_INSERTED) ? cmd.err
                                                                    : saq_pkg::ST_QUEUED;
                  rsp_ext_in    = ext_ff;
                  rsp_due_in    = '0;
                  rsp_pos_in    = saq_pkg::POS_W'(saq_pkg::NOT_PLACED);
                  rsp_head_in   = saq_pkg::POS_W'(head_ff);
               end else begin
                  state_in = S_DELTA;
               end
            end
         end
         S_DELTA: begin
            // elapsed ticks, wrapping at max_count
            if (now_ff < last_ff) begin
               delta_in = (max_count - last_ff) + now_ff + TW'(1);
            end else begin
               delta_in = now_ff - last_ff;
            end
            state_in = S_EXT;
         end
         S_EXT: begin
            ext_in   = ext_ff + delta_ff;
            last_in  = now_ff;
            state_in = S_DUE;
         end
         S_DUE: begin
            due_in             = due_sum;
            due_we             = 1'b1;
            in_queue_in[id_ff] = 1'b1;
            rd_addr            = head_ff[ID_W-1:0];
            if (head_ff >= LINK_W'(NA)) begin
               // empty queue: becomes the head
               next_we       = 1'b1;
               next_wd       = saq_pkg::NOT_PLACED;
               head_in       = LINK_W'(id_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = saq_pkg::ST_INSERTED;
               rsp_ext_in    = ext_ff;
               rsp_due_in    = due_sum;
               rsp_pos_in    = '0;
               rsp_head_in   = saq_pkg::POS_W'(id_ff);
               state_in      = S_IDLE;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (is_before(due_ff, rd_due_ff)) begin
               // new head
               next_we       = 1'b1;
               next_wd       = head_ff;
               head_in       = LINK_W'(id_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = saq_pkg::ST_INSERTED;
               rsp_ext_in    = ext_ff;
               rsp_due_in    = due_ff;
               rsp_pos_in    = '0;
               rsp_head_in   = saq_pkg::POS_W'(id_ff);
               state_in      = S_IDLE;
            end else begin
               prior_in = head_ff[ID_W-1:0];
               cur_in   = rd_next_ff;
               pos_in   = LINK_W'(1);
               guard_in = '0;
               rd_addr  = rd_next_ff[ID_W-1:0];
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // one queued entry per cycle; ties walk past
            if (walk_end) begin
               next_we  = 1'b1;
               next_wa  = prior_ff;
               next_wd  = LINK_W'(id_ff);
               state_in = S_LINK;
            end else begin
               prior_in = cur_ff[ID_W-1:0];
               cur_in   = rd_next_ff;
               pos_in   = pos_ff + LINK_W'(1);
               guard_in = guard_ff + LINK_W'(1);
               rd_addr  = rd_next_ff[ID_W-1:0];
            end
         end
         S_LINK: begin
            next_we       = 1'b1;
            next_wa       = id_ff;
            next_wd       = (cur_ff >= LINK_W'(NA)) ? saq_pkg::NOT_PLACED : cur_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = saq_pkg::ST_INSERTED;
            rsp_ext_in    = ext_ff;
            rsp_due_in    = due_ff;
            rsp_pos_in    = saq_pkg::POS_W'(pos_ff);
            rsp_head_in   = saq_pkg::POS_W'(head_ff);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ext_ff       <= '0;
         last_ff      <= '0;
         head_ff      <= saq_pkg::NOT_PLACED;
         in_queue_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ext_ff       <= ext_in;
         last_ff      <= last_in;
         head_ff      <= head_in;
         in_queue_ff  <= in_queue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      rel_ff        <= rel_in;
      now_ff        <= now_in;
      delta_ff      <= delta_in;
      due_ff        <= due_in;
      prior_ff      <= prior_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      guard_ff      <= guard_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ext_ff    <= rsp_ext_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_head_ff   <= rsp_head_in;
   end

   // tables: one write each, registered read
   always_ff @(posedge clock) begin
      if (due_we) begin
         due_mem[id_ff] <= due_sum;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      rd_due_ff  <= due_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
   end

endmodule
`default_nettype wire

### dv/tb_sorted_alarm_queue_insert_core.sv
`timescale 1ns / 100ps
module tb_sorted_alarm_queue_insert_core;

   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 550;
   localparam int TAIL_CYCLES  = 30;
   localparam int NA           = saq_pkg::NUM_ALARMS;

   // one expected result of an insert request
   typedef struct packed {
      logic [saq_pkg::STAT_W-1:0] status;
      logic [saq_pkg::TIME_W-1:0] extended_now;
      logic [saq_pkg::TIME_W-1:0] due_time;
      logic [saq_pkg::POS_W-1:0]  queue_position;
      logic [saq_pkg::POS_W-1:0]  head_id;
   } alarm_result_type;

   typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_type;

   // one row of the directed table
   typedef struct packed {
      row_kind_type                kind;
      logic [saq_pkg::IN_ID_W-1:0] alarm_id;
      logic [saq_pkg::TIME_W-1:0]  rel_ticks;
      logic [saq_pkg::TIME_W-1:0]  counter_now;
      logic [saq_pkg::TIME_W-1:0]  cfg_value;
      logic                        typed;
      alarm_result_type            want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                       csr_we;
   logic [saq_pkg::TIME_W-1:0] csr_wdata;

   saq_req_if req_bus();
   saq_rsp_if rsp_bus();

   sorted_alarm_queue_insert_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the alarm queue
   logic [saq_pkg::TIME_W-1:0] max_count_shadow;
   logic [saq_pkg::TIME_W-1:0] run_time;
   logic [saq_pkg::TIME_W-1:0] last_counter;
   int                         head_slot;
   logic                       queued    [NA];
   logic [saq_pkg::TIME_W-1:0] due_tab   [NA];
   int                         next_tab  [NA];
   int                         prev_tab  [NA];

   alarm_result_type pending_results[$];
   stim_row_type     stim_rows[$];
   alarm_result_type want_rsp;

   int mismatches  = 0;
   int idle_cycles = 0;
   int src_idle_pct;
   int snk_idle_pct;

   always #10 clock = ~clock;

   // wrap-aware: a strictly before b
   function automatic logic due_precedes(input logic [saq_pkg::TIME_W-1:0] a,
                                         input logic [saq_pkg::TIME_W-1:0] b);
      logic [saq_pkg::TIME_W-1:0] diff;
      diff = a - b;
      return diff[saq_pkg::TIME_W-1];
   endfunction

   // check the request; if accepted, extend the reading, compute due time and link it into the queue
   function automatic alarm_result_type insert_alarm(
         input logic [saq_pkg::IN_ID_W-1:0] id_in,
         input logic [saq_pkg::TIME_W-1:0]  rel,
         input logic [saq_pkg::TIME_W-1:0]  now);
      alarm_result_type           r;
      int                         slot;
      int                         prior;
      int                         cur;
      int                         guard;
      int                         pos;
      logic [saq_pkg::TIME_W-1:0] elapsed;
      logic [saq_pkg::TIME_W-1:0] due;
      slot = int'(id_in) % NA;
      due  = '0;
      pos  = int'(saq_pkg::NOT_PLACED);
      if (now > max_count_shadow)
         r.status = saq_pkg::ST_BAD_NOW;
      else if (rel > max_count_shadow)
         r.status = saq_pkg::ST_BAD_REL;
      else if (queued[slot])
         r.status = saq_pkg::ST_QUEUED;
      else
         r.status = saq_pkg::ST_INSERTED;

      if (r.status == saq_pkg::ST_INSERTED) begin
         if (now < last_counter)
            elapsed = (max_count_shadow - last_counter) + now + 32'd1;
         else
            elapsed = now - last_counter;
         run_time      = run_time + elapsed;
         last_counter  = now;
         due           = run_time + rel;
         due_tab[slot] = due;
         queued[slot]  = 1'b1;

         if (head_slot >= NA) begin
            // empty queue
            next_tab[slot] = NA;
            prev_tab[slot] = NA;
            head_slot      = slot;
            pos            = 0;
         end else if (due_precedes(due, due_tab[head_slot])) begin
            // new head
            prev_tab[head_slot] = slot;
            next_tab[slot]      = head_slot;
            prev_tab[slot]      = NA;
            head_slot           = slot;
            pos                 = 0;
         end else begin
            // walk past entries due no later than this one
            prior = head_slot;
            cur   = next_tab[prior];
            guard = 0;
            pos   = 1;
            while (cur < NA && guard < NA && !due_precedes(due, due_tab[cur])) begin
               prior = cur;
               cur   = next_tab[cur];
               pos++;
               guard++;
            end
            if (cur >= NA)
               cur = NA;
            next_tab[prior] = slot;
            next_tab[slot]  = cur;
            prev_tab[slot]  = prior;
            if (cur < NA)
               prev_tab[cur] = slot;
         end
      end

      r.extended_now   = run_time;
      r.due_time       = due;
      r.queue_position = saq_pkg::POS_W'(pos);
      r.head_id        = saq_pkg::POS_W'(head_slot);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [saq_pkg::TIME_W-1:0] got,
                                input logic [saq_pkg::TIME_W-1:0] want);
      $display("mismatch @%0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic add_req(input logic [saq_pkg::IN_ID_W-1:0] id,
                          input logic [saq_pkg::TIME_W-1:0]  rel,
                          input logic [saq_pkg::TIME_W-1:0]  now);
      stim_rows.push_back('{ROW_REQ, id, rel, now, '0, 1'b0, '0});
   endtask

   task automatic add_checked(input logic [saq_pkg::IN_ID_W-1:0] id,
                              input logic [saq_pkg::TIME_W-1:0]  rel,
                              input logic [saq_pkg::TIME_W-1:0]  now,
                              input alarm_result_type            want);
      stim_rows.push_back('{ROW_REQ, id, rel, now, '0, 1'b1, want});
   endtask

   task automatic add_cfg(input logic [saq_pkg::TIME_W-1:0] value);
      stim_rows.push_back('{ROW_CFG, '0, '0, '0, value, 1'b0, '0});
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   // write max_count only with nothing in flight
   task automatic write_max_count(input logic [saq_pkg::TIME_W-1:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we           = 1'b0;
      max_count_shadow = value;
   endtask

   // present one request, hold until accepted, record its expected result
   task automatic send_request(input logic [saq_pkg::IN_ID_W-1:0] id,
                               input logic [saq_pkg::TIME_W-1:0]  rel,
                               input logic [saq_pkg::TIME_W-1:0]  now,
                               input logic                        typed,
                               input alarm_result_type            want);
      alarm_result_type predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.alarm_id    = id;
      req_bus.rel_ticks   = rel;
      req_bus.counter_now = now;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = insert_alarm(id, rel, now);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic logic [saq_pkg::TIME_W-1:0] rand_upto(
         input logic [saq_pkg::TIME_W-1:0] limit);
      if (limit == '1)
         return $urandom;
      return $urandom_range(limit, 0);
   endfunction

   function automatic logic [saq_pkg::TIME_W-1:0] rand_above(
         input logic [saq_pkg::TIME_W-1:0] limit);
      if (limit == '1)
         return $urandom;
      return $urandom_range(32'hFFFF_FFFF, limit + 32'd1);
   endfunction

   // mostly legal requests on free alarms, some out of range or duplicate
   task automatic make_random_request(output logic [saq_pkg::IN_ID_W-1:0] id,
                                      output logic [saq_pkg::TIME_W-1:0]  rel,
                                      output logic [saq_pkg::TIME_W-1:0]  now);
      int free_ids[$];
      int roll;
      for (int i = 0; i < NA; i++)
         if (!queued[i])
            free_ids.push_back(i);
      if (free_ids.size() != 0 && $urandom_range(99) < 60)
         id = saq_pkg::IN_ID_W'(free_ids[$urandom_range(free_ids.size() - 1, 0)]);
      else
         id = saq_pkg::IN_ID_W'($urandom_range(NA - 1, 0));
      roll = $urandom_range(99);
      if (roll < 80) begin
         now = rand_upto(max_count_shadow);
         case ($urandom_range(3))
            0:       rel = '0;
            1:       rel = max_count_shadow;
            default: rel = rand_upto(max_count_shadow);
         endcase
      end else if (roll < 90) begin
         now = rand_above(max_count_shadow);
         rel = $urandom;
      end else begin
         now = rand_upto(max_count_shadow);
         rel = rand_above(max_count_shadow);
      end
   endtask

   // receiver backpressure
   always @(negedge clock)
      rsp_bus.ready = ($urandom_range(99) >= snk_idle_pct);

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result with no request pending", 32'(rsp_bus.status), '0);
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_bus.status !== want_rsp.status)
               flag_mismatch("status", 32'(rsp_bus.status), 32'(want_rsp.status));
            if (rsp_bus.extended_now !== want_rsp.extended_now)
               flag_mismatch("extended_now", rsp_bus.extended_now, want_rsp.extended_now);
            if (rsp_bus.due_time !== want_rsp.due_time)
               flag_mismatch("due_time", rsp_bus.due_time, want_rsp.due_time);
            if (rsp_bus.queue_position !== want_rsp.queue_position)
               flag_mismatch("queue_position", 32'(rsp_bus.queue_position),
                             32'(want_rsp.queue_position));
            if (rsp_bus.head_id !== want_rsp.head_id)
               flag_mismatch("head_id", 32'(rsp_bus.head_id), 32'(want_rsp.head_id));
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [saq_pkg::IN_ID_W-1:0] rid;
      logic [saq_pkg::TIME_W-1:0]  rrel;
      logic [saq_pkg::TIME_W-1:0]  rnow;
      logic [saq_pkg::TIME_W-1:0]  phase_max;

      clock               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.alarm_id    = '0;
      req_bus.rel_ticks   = '0;
      req_bus.counter_now = '0;
      rsp_bus.ready       = 1'b0;
      src_idle_pct        = 14;
      snk_idle_pct        = 64;

      // shadow state after reset
      max_count_shadow = 32'd65535;
      run_time         = '0;
      last_counter     = '0;
      head_slot        = NA;
      for (int i = 0; i < NA; i++) begin
         queued[i]   = 1'b0;
         due_tab[i]  = '0;
         next_tab[i] = 0;
         prev_tab[i] = 0;
      end

      // directed table
      add_checked(4'd3, 32'd100, 32'd0,
                  '{saq_pkg::ST_INSERTED, 32'd0, 32'd100, 5'd0, 5'd3});
      add_checked(4'd4, 32'd0, 32'd65536,
                  '{saq_pkg::ST_BAD_NOW, 32'd0, 32'd0, saq_pkg::NOT_PLACED, 5'd3});
      add_checked(4'd4, 32'd65536, 32'd0,
                  '{saq_pkg::ST_BAD_REL, 32'd0, 32'd0, saq_pkg::NOT_PLACED, 5'd3});
      // both out of range: reading check wins
      add_checked(4'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  '{saq_pkg::ST_BAD_NOW, 32'd0, 32'd0, saq_pkg::NOT_PLACED, 5'd3});
      add_checked(4'd3, 32'd5, 32'd0,
                  '{saq_pkg::ST_QUEUED, 32'd0, 32'd0, saq_pkg::NOT_PLACED, 5'd3});
      add_req(4'd5, 32'd100, 32'd0);            // tie goes behind
      add_req(4'd7, 32'd10, 32'd0);             // earlier than head
      add_req(4'd9, 32'd50, 32'd0);             // middle
      add_req(4'd10, 32'd65535, 32'd65535);     // both at max
      add_req(4'd11, 32'd0, 32'd5);             // counter wrap
      add_cfg(32'd1);
      add_req(4'd12, 32'd1, 32'd1);
      add_req(4'd13, 32'd0, 32'd0);             // wrap modulo 2
      add_req(4'd4, 32'd0, 32'd2);
      add_req(4'd4, 32'd2, 32'd1);
      add_cfg(32'hFFFF_FFFF);
      add_req(4'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_req(4'd15, 32'h8000_0000, 32'h9000_0000);
      add_cfg(32'd100);                          // lowered below last reading
      add_req(4'd0, 32'd100, 32'd50);
      add_req(4'd0, 32'd0, 32'd0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CFG)
            write_max_count(stim_rows[i].cfg_value);
         else
            send_request(stim_rows[i].alarm_id, stim_rows[i].rel_ticks,
                         stim_rows[i].counter_now, stim_rows[i].typed, stim_rows[i].want);
      end

      // random phases: sender-light idling, receiver-light idling, none
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               src_idle_pct = 14;
               snk_idle_pct = 64;
               phase_max    = 32'hFFFF_FFFF;
            end
            1: begin
               src_idle_pct = 64;
               snk_idle_pct = 14;
               phase_max    = $urandom_range(32'hFFFF_FFFE, 1);
            end
            default: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
               phase_max    = $urandom_range(2000, 2);
            end
         endcase
         write_max_count(phase_max);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == PHASE_ITEMS / 2)
               wait_drained();
            make_random_request(rid, rrel, rnow);
            send_request(rid, rrel, rnow, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
